// File: rtl/pbr_pkg.sv
// Package for the page bitmap range engine: sizes, opcodes and mask helpers.
package pbr_pkg;

    // Bitmap geometry.
    localparam int NUM_BITS  = 65536;
    localparam int WORD_BITS = 32;
    localparam int NUM_WORDS = NUM_BITS / WORD_BITS;
    localparam int WORD_W    = $clog2(WORD_BITS);
    localparam int ADDR_W    = $clog2(NUM_WORDS);

    // Widths of the command and register fields.
    localparam int FIELD_W  = 17;
    localparam int OP_W     = 3;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 2;

    // Largest usable map size.
    localparam logic [FIELD_W-1:0] SIZE_MAX = FIELD_W'(NUM_BITS);

    // Register byte addresses.
    localparam logic [APB_AW-1:0] REG_MAP_SIZE = APB_AW'(0);

    // Command opcodes.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE_BIT = 3'd0,
        OP_SET_BIT   = 3'd1,
        OP_CLR_BIT   = 3'd2,
        OP_READ_BIT  = 3'd3,
        OP_SET_RANGE = 3'd4,
        OP_CLR_RANGE = 3'd5
    } op_t;

    // A mask with the low n bits set, n from 0 to WORD_BITS.
    function automatic logic [WORD_BITS-1:0] low_ones(input logic [WORD_W:0] n);
        logic [WORD_BITS:0] full;
        begin
            full = ((WORD_BITS+1)'(1) << n) - (WORD_BITS+1)'(1);
            return full[WORD_BITS-1:0];
        end
    endfunction

endpackage

// File: rtl/page_bitmap_range_engine.sv
// Top level: command sequencer over the bitmap RAM and the shared mask unit.
// A bit op passes the check, read and write states before its result shows;
// a range op passes the check state, then a read and a write state per word
// it covers, since each word is one read-modify-write of the single RAM port.
// Rejected commands and empty ranges answer from the check state. A new command
// is taken in the cycle the result shows. After reset, busy stays high while the
// RAM is cleared one word a cycle; results cannot be stalled by the receiver.
module page_bitmap_range_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [pbr_pkg::OP_W-1:0]    opcode,
    input  logic [pbr_pkg::FIELD_W-1:0] bit_index,
    input  logic [pbr_pkg::FIELD_W-1:0] range_length,
    input  logic                        bit_value,
    output logic                        done,
    output logic                        status,
    output logic                        read_bit,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbr_pkg::APB_AW-1:0]  paddr,
    input  logic [pbr_pkg::APB_DW-1:0]  pwdata,
    output logic [pbr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    import pbr_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_CHECK = 5'b00100,
        S_READ  = 5'b01000,
        S_WRITE = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [FIELD_W-1:0]   idx_reg, idx_next;
    logic [FIELD_W-1:0]   len_reg, len_next;
    logic                 val_reg, val_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [ADDR_W-1:0]    last_reg, last_next;
    logic [WORD_W-1:0]    endlo_reg, endlo_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic                 done_reg, done_next;
    logic                 status_reg, status_next;
    logic                 rdbit_reg, rdbit_next;

    logic [FIELD_W-1:0]   eff_size;
    logic [FIELD_W:0]     end_sum;
    logic [FIELD_W:0]     end_m1;
    logic                 is_single;
    logic                 is_range;
    logic                 cmd_err;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [WORD_W-1:0]    mu_lo;
    logic [WORD_W:0]      mu_hi;
    logic                 mu_set;
    logic [WORD_BITS-1:0] mu_word;
    logic                 mu_bit;

    // Configuration registers.
    pbr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .eff_size (eff_size)
    );

    // Bitmap storage.
    pbr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Shared mask unit, used once per word visited.
    pbr_mask_unit u_mask (
        .word_in  (ram_rdata),
        .lo       (mu_lo),
        .hi       (mu_hi),
        .set      (mu_set),
        .word_out (mu_word),
        .bit_out  (mu_bit)
    );

    // Command decode and bound checks.
    assign is_single = (op_reg == OP_WRITE_BIT) || (op_reg == OP_SET_BIT) ||
                       (op_reg == OP_CLR_BIT) || (op_reg == OP_READ_BIT);
    assign is_range  = (op_reg == OP_SET_RANGE) || (op_reg == OP_CLR_RANGE);
    assign end_sum   = {1'b0, idx_reg} + {1'b0, len_reg};
    assign end_m1    = end_sum - (FIELD_W+1)'(1);

    always_comb
    begin
        if (is_single)
        begin
            cmd_err = (idx_reg >= eff_size);
        end
        else if (is_range)
        begin
            cmd_err = (idx_reg > eff_size) || (end_sum > {1'b0, eff_size});
        end
        else
        begin
            cmd_err = 1'b1;
        end
    end

    // Mask span for the current word; a bit op is a one-bit span.
    assign mu_lo  = (addr_reg == idx_reg[WORD_W +: ADDR_W]) ? idx_reg[WORD_W-1:0] : '0;
    assign mu_hi  = (addr_reg == last_reg) ? ({1'b0, endlo_reg} + (WORD_W+1)'(1))
                                           : (WORD_W+1)'(WORD_BITS);
    assign mu_set = (op_reg == OP_SET_BIT) || (op_reg == OP_SET_RANGE) ||
                    ((op_reg == OP_WRITE_BIT) && val_reg);

    // RAM port: clearing pass after reset, else the sequencer's word.
    assign ram_we    = (state_reg == S_CLEAR) ||
                       ((state_reg == S_WRITE) && (op_reg != OP_READ_BIT));
    assign ram_addr  = (state_reg == S_CLEAR) ? clr_reg : addr_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : mu_word;

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        val_next    = val_reg;
        addr_next   = addr_reg;
        last_next   = last_reg;
        endlo_next  = endlo_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rdbit_next  = rdbit_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(NUM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op_t'(opcode);
                    idx_next   = bit_index;
                    len_next   = range_length;
                    val_next   = bit_value;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                addr_next = idx_reg[WORD_W +: ADDR_W];
                if (is_single)
                begin
                    last_next  = idx_reg[WORD_W +: ADDR_W];
                    endlo_next = idx_reg[WORD_W-1:0];
                end
                else
                begin
                    last_next  = end_m1[WORD_W +: ADDR_W];
                    endlo_next = end_m1[WORD_W-1:0];
                end
                if (cmd_err || (is_range && (len_reg == '0)))
                begin
                    done_next   = 1'b1;
                    status_next = cmd_err;
                    rdbit_next  = 1'b0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (addr_reg == last_reg)
                begin
                    done_next   = 1'b1;
                    status_next = 1'b0;
                    rdbit_next  = (op_reg == OP_READ_BIT) && mu_bit;
                    state_next  = S_IDLE;
                end
                else
                begin
                    addr_next  = addr_reg + ADDR_W'(1);
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    // Command and result words.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        len_reg    <= len_next;
        val_reg    <= val_next;
        addr_reg   <= addr_next;
        last_reg   <= last_next;
        endlo_reg  <= endlo_next;
        status_reg <= status_next;
        rdbit_reg  <= rdbit_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign read_bit = rdbit_reg;

`ifndef SYNTH
    // No result word comes out during the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !done_reg)
        else $error("result strobe during clearing pass");

    // An accepted command always goes to the bound check next.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_CHECK))
        else $error("accepted command did not reach check");

    // The word walk never runs past the last word of its span.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> (addr_reg <= last_reg))
        else $error("word address beyond end of span");

    // A rejected command never reports a set bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg) |-> !rdbit_reg)
        else $error("read bit set on error result");

    // The RAM is written only when clearing or finishing a modify.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_CLEAR) || (state_reg == S_WRITE)))
        else $error("RAM write outside clear or write state");
`endif

endmodule

// File: rtl/pbr_ram.sv
// Generic single-port RAM with registered read data.
module pbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle: write, and read the addressed word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/pbr_mask_unit.sv
// Shared mask unit: builds a bit-span mask and applies it to one bitmap word.
module pbr_mask_unit (
    input  logic [pbr_pkg::WORD_BITS-1:0] word_in,
    input  logic [pbr_pkg::WORD_W-1:0]    lo,
    input  logic [pbr_pkg::WORD_W:0]      hi,
    input  logic                          set,
    output logic [pbr_pkg::WORD_BITS-1:0] word_out,
    output logic                          bit_out
);

    import pbr_pkg::*;

    logic [WORD_BITS-1:0] mask;

    // Bits lo up to hi-1 are selected.
    assign mask = low_ones(hi) & ~low_ones({1'b0, lo});

    // Set or clear the selected bits; also report whether any was set.
    assign word_out = set ? (word_in | mask) : (word_in & ~mask);
    assign bit_out  = |(word_in & mask);

endmodule

// File: rtl/pbr_cfg.sv
// APB register block holding the map size register.
module pbr_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbr_pkg::APB_AW-1:0]  paddr,
    input  logic [pbr_pkg::APB_DW-1:0]  pwdata,
    output logic [pbr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [pbr_pkg::FIELD_W-1:0] eff_size
);

    import pbr_pkg::*;

    logic [FIELD_W-1:0] map_size_reg;
    logic [FIELD_W-1:0] map_size_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == REG_MAP_SIZE);

    // Register write in the access phase.
    always_comb
    begin
        map_size_next = map_size_reg;
        if (wr_en)
        begin
            map_size_next = pwdata[FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_size_reg <= SIZE_MAX;
        end
        else
        begin
            map_size_reg <= map_size_next;
        end
    end

    // Read back the stored value.
    assign prdata = (paddr == REG_MAP_SIZE) ? {{(APB_DW-FIELD_W){1'b0}}, map_size_reg}
                                             : '0;

    // Sizes above the bitmap act as the full bitmap.
    assign eff_size = (map_size_reg > SIZE_MAX) ? SIZE_MAX : map_size_reg;

endmodule
